@@ design/bdlp_pkg.sv @@
// ----------------------------------------------------------------------------
// bdlp_pkg
// Shared types and constants of the button debouncer with long-press repeat.
// ----------------------------------------------------------------------------
`default_nettype none

package bdlp_pkg;

   // default time geometry: ms counter wraps at 2^10, ticks of 2^4 ms
   localparam int TIME_WRAP_BITS_DEF = 10;
   localparam int TICK_SHIFT_DEF     = 4;

   // configuration registers
   localparam int CFG_W      = 10;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   localparam logic [CFG_W-1:0] PRESS_DEB_RST = CFG_W'(32);
   localparam logic [CFG_W-1:0] LONG_PRESS_RST = CFG_W'(512);
   localparam logic [CFG_W-1:0] REPEAT_RST     = CFG_W'(160);
   localparam logic [CFG_W-1:0] REL_DEB_RST    = CFG_W'(64);

   typedef enum logic [1:0] {
      REG_PRESS_DEB  = 2'd0,
      REG_LONG_PRESS = 2'd1,
      REG_REPEAT     = 2'd2,
      REG_REL_DEB    = 2'd3
   } reg_idx_type;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_PRESS_DEB = 3'd1,
      PH_REL_DEB   = 3'd2,
      PH_PRESSED   = 3'd3,
      PH_LONG      = 3'd4,
      PH_LONG_REL  = 3'd5,
      PH_SHORT_REL = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      EV_NONE       = 3'd0,
      EV_SHORT      = 3'd1,
      EV_FIRST_LONG = 3'd2,
      EV_REPEAT     = 3'd3,
      EV_LONG_DONE  = 3'd4
   } evt_type;

endpackage

`default_nettype wire

@@ design/button_debounce_long_press.sv @@
// ----------------------------------------------------------------------------
// button_debounce_long_press
// Polled button debouncer reporting short press, first long press, repeated
// long presses and long-press-done, with a held flag on every result.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------
//  req     | in        | req_valid / req_stall | req_level, req_time_ms
//  rsp     | out       | rsp_valid / rsp_stall | rsp_event_code, rsp_held
//  csr     | in/out    | apb, pready always 1 | four 10-bit ms thresholds
//
//  one item per cycle sustained while rsp_stall is low; an accepted item
//  goes through the input register, then the result register, where its
//  result is valid and can be taken
//  phase and tick stamp are updated at the same edge that loads the result
//  register, so the next item always sees the state left by the previous one
//  a stalled result holds; the input register keeps taking items as long as
//  it is empty or the result register is free or being emptied in that cycle
//  reset (synchronous) clears both valids, returns the phase to idle, the
//  stamp to zero and the thresholds to their defaults
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_long_press #(
   parameter int TIME_WRAP_BITS = bdlp_pkg::TIME_WRAP_BITS_DEF,
   parameter int TICK_SHIFT     = bdlp_pkg::TICK_SHIFT_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // poll items
   input  wire logic                            req_valid,
   output      logic                            req_stall,
   input  wire logic                            req_level,
   input  wire logic [TIME_WRAP_BITS-1:0]       req_time_ms,
   // results
   output      logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   output      logic [2:0]                      rsp_event_code,
   output      logic                            rsp_held,
   // configuration
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [bdlp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [bdlp_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output      logic [bdlp_pkg::CSR_DATA_W-1:0] csr_prdata,
   output      logic                            csr_pready
);
   import bdlp_pkg::*;

   // tick counter width and compare width for elapsed time against thresholds
   localparam int TICK_BITS = TIME_WRAP_BITS - TICK_SHIFT;
   localparam int CMP_W     = (TIME_WRAP_BITS > CFG_W) ? TIME_WRAP_BITS : CFG_W;

   // ------------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------------
   logic [CFG_W-1:0] press_deb_ff;
   logic [CFG_W-1:0] long_press_ff;
   logic [CFG_W-1:0] repeat_ff;
   logic [CFG_W-1:0] rel_deb_ff;
   logic             csr_wr;
   reg_idx_type      csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   // byte address 4*i, word index from the upper address bits
   assign csr_idx    = reg_idx_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         press_deb_ff  <= PRESS_DEB_RST;
         long_press_ff <= LONG_PRESS_RST;
         repeat_ff     <= REPEAT_RST;
         rel_deb_ff    <= REL_DEB_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_PRESS_DEB:  press_deb_ff  <= csr_pwdata[CFG_W-1:0];
            REG_LONG_PRESS: long_press_ff <= csr_pwdata[CFG_W-1:0];
            REG_REPEAT:     repeat_ff     <= csr_pwdata[CFG_W-1:0];
            REG_REL_DEB:    rel_deb_ff    <= csr_pwdata[CFG_W-1:0];
            default:        ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (csr_idx)
         REG_PRESS_DEB:  csr_prdata = CSR_DATA_W'(press_deb_ff);
         REG_LONG_PRESS: csr_prdata = CSR_DATA_W'(long_press_ff);
         REG_REPEAT:     csr_prdata = CSR_DATA_W'(repeat_ff);
         REG_REL_DEB:    csr_prdata = CSR_DATA_W'(rel_deb_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // pipeline handshake
   // ------------------------------------------------------------------------
   logic                 in_valid_ff;
   logic                 in_level_ff;
   logic [TICK_BITS-1:0] in_now_ff;     // poll time already cut to ticks
   logic                 out_valid_ff;
   logic [2:0]           out_code_ff;
   logic                 out_held_ff;

   logic out_free;   // result register can take a new value this cycle
   logic advance;    // input register moves into the result register
   logic req_take;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   // payload, no reset needed; bits above the wrap are never seen
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_level_ff <= req_level;
         in_now_ff   <= req_time_ms[TIME_WRAP_BITS-1:TICK_SHIFT];
      end
   end

   // ------------------------------------------------------------------------
   // phase machine, one step per advancing item
   // ------------------------------------------------------------------------
   phase_type            phase_ff;
   phase_type            phase_in;
   logic [TICK_BITS-1:0] stamp_ff;
   logic [TICK_BITS-1:0] stamp_in;
   logic [TICK_BITS-1:0] tick_diff;
   logic [TIME_WRAP_BITS-1:0] elapsed;
   evt_type              evt;
   logic                 high;
   logic                 ge_press;
   logic                 ge_long;
   logic                 ge_repeat;
   logic                 ge_rel;

   // elapsed ms since the stamp, modulo the wrap period
   assign tick_diff = in_now_ff - stamp_ff;
   assign elapsed   = TIME_WRAP_BITS'(tick_diff) << TICK_SHIFT;
   assign high      = in_level_ff;

   assign ge_press  = CMP_W'(elapsed) >= CMP_W'(press_deb_ff);
   assign ge_long   = CMP_W'(elapsed) >= CMP_W'(long_press_ff);
   assign ge_repeat = CMP_W'(elapsed) >= CMP_W'(repeat_ff);
   assign ge_rel    = CMP_W'(elapsed) >= CMP_W'(rel_deb_ff);

   always_comb begin
      phase_in = phase_ff;
      stamp_in = stamp_ff;
      evt      = EV_NONE;
      unique case (phase_ff)
         PH_PRESS_DEB: begin
            if (high) begin
               phase_in = PH_IDLE;        // bounce, give up
            end else if (ge_press) begin
               phase_in = PH_PRESSED;
            end
         end
         PH_PRESSED: begin
            if (high) begin
               phase_in = PH_SHORT_REL;
               stamp_in = in_now_ff;
            end else if (ge_long) begin
               evt      = EV_FIRST_LONG;
               phase_in = PH_LONG;
               stamp_in = in_now_ff;
            end
         end
         PH_LONG: begin
            if (high) begin
               phase_in = PH_LONG_REL;
            end else if (ge_repeat) begin
               evt      = EV_REPEAT;
               stamp_in = in_now_ff;
            end
         end
         PH_LONG_REL: begin
            // release has to be seen on two polls running
            if (high) begin
               evt      = EV_LONG_DONE;
               phase_in = PH_REL_DEB;
               stamp_in = in_now_ff;
            end else begin
               phase_in = PH_LONG;
            end
         end
         PH_SHORT_REL: begin
            if (high) begin
               evt      = EV_SHORT;
               phase_in = PH_REL_DEB;
            end else begin
               phase_in = PH_PRESSED;
            end
         end
         PH_REL_DEB: begin
            // any low restarts the release timer
            if (high) begin
               if (ge_rel) begin
                  phase_in = PH_IDLE;
               end
            end else begin
               stamp_in = in_now_ff;
            end
         end
         default: begin
            // idle, and the unused code behaves as idle
            phase_in = PH_IDLE;
            if (!high) begin
               phase_in = PH_PRESS_DEB;
               stamp_in = in_now_ff;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         stamp_ff <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         stamp_ff <= stamp_in;
      end
   end

   // ------------------------------------------------------------------------
   // result register
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_code_ff <= evt;
         // held: pressed, long press or either release check
         out_held_ff <= (phase_in == PH_PRESSED)  || (phase_in == PH_LONG) ||
                        (phase_in == PH_LONG_REL) || (phase_in == PH_SHORT_REL);
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_event_code = out_code_ff;
   assign rsp_held       = out_held_ff;

endmodule

`default_nettype wire

@@ design/bdlp_checker.sv @@
// ----------------------------------------------------------------------------
// bdlp_checker
// Port-level checks on the result channel of the button debouncer.
// ----------------------------------------------------------------------------
`default_nettype none

module bdlp_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [2:0] rsp_event_code,
   input wire logic       rsp_held
);
   import bdlp_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_event_code) && $stable(rsp_held))
      else $error("stalled result changed");

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_event_code <= EV_LONG_DONE))
      else $error("event code out of range");

   // release events leave the button released
   a_release_not_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_code == EV_SHORT || rsp_event_code == EV_LONG_DONE)
         |-> !rsp_held)
      else $error("held set on a release event");

   // long press events happen while the button is down
   a_long_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_code == EV_FIRST_LONG || rsp_event_code == EV_REPEAT)
         |-> rsp_held)
      else $error("held clear on a long press event");

endmodule

bind button_debounce_long_press bdlp_checker u_bdlp_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_event_code (rsp_event_code),
   .rsp_held       (rsp_held)
);

`default_nettype wire
